// ===== design/fst_pkg.sv =====
// ----------------------------------------------------------------------------
// fst_pkg : shared types and constants of the fixed-timestep frame timer
// command and status bundles between controller and datapath, field widths,
// operation and result codes, register indexes and reset values
// ----------------------------------------------------------------------------
package fst_pkg;

   // field widths of the transactions
   localparam int ElapsedW   = 32;
   localparam int StepW      = 32;
   localparam int OutTimeW   = 48;
   localparam int FrameW     = 48;
   localparam int ScaleW     = 16;
   localparam int FixedStepW = 20;
   localparam int MaxDeltaW  = 32;
   localparam int CsrIdxW    = 2;
   localparam int CsrDataW   = 32;
   localparam int ProductW   = ElapsedW + ScaleW;
   localparam int ScaleFracW = 8;
   localparam int RspDataW   = StepW + 4 * OutTimeW;

   // input operation codes
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // result kinds
   localparam logic KIND_STEP  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_TIME_SCALE = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_FIXED_STEP = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_MAX_DELTA  = 2'd2;

   // register reset values
   localparam logic [ScaleW-1:0]     TIME_SCALE_RST = 16'd256;
   localparam logic [FixedStepW-1:0] FIXED_STEP_RST = 20'd20000;
   localparam logic [MaxDeltaW-1:0]  MAX_DELTA_RST  = 32'd100000;

   // controller to datapath
   typedef struct packed {
      logic capture;     // load elapsed time and its clamped copy
      logic restart;     // clear times, arm first tick
      logic mul;         // scale the clamped time
      logic acc;         // accumulate into the time registers
      logic emit_step;   // advance fixed time, load a fixed-step result
      logic emit_frame;  // load the frame result, count the frame
   } fst_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic due;         // another fixed step is owed this tick
      logic out_free;    // result register can take a new result
   } fst_status_type;

endpackage

// ===== design/fst_ctrl.sv =====
// ----------------------------------------------------------------------------
// fst_ctrl : sequencing controller of the frame timer
// walks each tick through scale, accumulate and the serial result loop
// ----------------------------------------------------------------------------
module fst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_op,
   input  fst_pkg::fst_status_type status,
   output fst_pkg::fst_cmd_type    cmd
);
   import fst_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_op == OP_RESTART) begin
                  cmd.restart = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // one result per cycle while the result register drains
            if (status.out_free) begin
               if (status.due) begin
                  cmd.emit_step = 1'b1;
               end else begin
                  cmd.emit_frame = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/fst_dp.sv =====
// ----------------------------------------------------------------------------
// fst_dp : datapath of the frame timer
// control registers, clamp and scale, time accumulators, step counter and
// the result register
// ----------------------------------------------------------------------------
module fst_dp #(
   parameter int MAX_FIXED_STEPS = 63,
   parameter int TIME_WIDTH      = 48
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [fst_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [fst_pkg::CsrDataW-1:0]    csr_data,
   input  logic [fst_pkg::ElapsedW-1:0]    elapsed,
   input  fst_pkg::fst_cmd_type            cmd,
   output fst_pkg::fst_status_type         status,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fst_pkg::RspDataW-1:0]    rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import fst_pkg::*;

   localparam int CntW = $clog2(MAX_FIXED_STEPS + 1);

   // control registers
   logic [ScaleW-1:0]     scale_ff;
   logic [FixedStepW-1:0] fstep_ff;
   logic [MaxDeltaW-1:0]  maxd_ff;

   // per-tick working registers
   logic [ElapsedW-1:0]   elapsed_ff;
   logic [ElapsedW-1:0]   clamped_ff;
   logic [ProductW-1:0]   product_ff;
   logic [StepW-1:0]      delta_ff;
   logic [CntW-1:0]       nstep_ff;

   // timer state
   logic                  first_ff;
   logic [TIME_WIDTH-1:0] game_ff;
   logic [TIME_WIDTH-1:0] unscaled_ff;
   logic [TIME_WIDTH-1:0] fixed_ff;
   logic [FrameW-1:0]     frame_ff;

   // result register
   logic                  valid_ff;
   logic                  kind_ff;
   logic                  last_ff;
   logic [StepW-1:0]      ostep_ff;
   logic [OutTimeW-1:0]   ogame_ff;
   logic [OutTimeW-1:0]   ounscaled_ff;
   logic [OutTimeW-1:0]   ofixed_ff;
   logic [FrameW-1:0]     oframe_ff;

   logic [TIME_WIDTH-1:0] lead;
   logic [TIME_WIDTH-1:0] fixed_next;
   logic [TIME_WIDTH-1:0] scaled;

   assign lead       = game_ff - fixed_ff;
   assign fixed_next = fixed_ff + TIME_WIDTH'(fstep_ff);
   assign scaled     = TIME_WIDTH'(product_ff >> ScaleFracW);

   assign status.due = (fstep_ff != '0) && (nstep_ff < CntW'(MAX_FIXED_STEPS)) &&
                       (lead >= TIME_WIDTH'(fstep_ff));
   assign status.out_free = !valid_ff || rsp_tready;

   // register writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= TIME_SCALE_RST;
         fstep_ff <= FIXED_STEP_RST;
         maxd_ff  <= MAX_DELTA_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TIME_SCALE: scale_ff <= csr_data[ScaleW-1:0];
            CSR_FIXED_STEP: fstep_ff <= csr_data[FixedStepW-1:0];
            CSR_MAX_DELTA:  maxd_ff  <= csr_data[MaxDeltaW-1:0];
            default: begin
            end
         endcase
      end
   end

   // working registers, payload only
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         elapsed_ff <= elapsed;
         clamped_ff <= (elapsed < maxd_ff) ? elapsed : maxd_ff;
      end
      if (cmd.mul) begin
         product_ff <= ProductW'(clamped_ff) * ProductW'(scale_ff);
      end
      if (cmd.acc) begin
         delta_ff <= first_ff ? '0 : elapsed_ff;
      end
   end

   // timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff    <= 1'b1;
         game_ff     <= '0;
         unscaled_ff <= '0;
         fixed_ff    <= '0;
         frame_ff    <= '0;
         nstep_ff    <= '0;
      end else begin
         if (cmd.restart) begin
            first_ff    <= 1'b1;
            game_ff     <= '0;
            unscaled_ff <= '0;
            fixed_ff    <= '0;
         end
         if (cmd.capture) begin
            nstep_ff <= '0;
         end
         if (cmd.acc) begin
            if (first_ff) begin
               // first tick after restart counts as zero elapsed
               first_ff    <= 1'b0;
               game_ff     <= '0;
               unscaled_ff <= '0;
               fixed_ff    <= '0;
            end else begin
               game_ff     <= game_ff + scaled;
               unscaled_ff <= unscaled_ff + TIME_WIDTH'(elapsed_ff);
            end
         end
         if (cmd.emit_step) begin
            fixed_ff <= fixed_next;
            nstep_ff <= nstep_ff + 1'b1;
         end
         if (cmd.emit_frame) begin
            frame_ff <= frame_ff + 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit_step || cmd.emit_frame) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_step || cmd.emit_frame) begin
         ogame_ff     <= OutTimeW'(game_ff);
         ounscaled_ff <= OutTimeW'(unscaled_ff);
         oframe_ff    <= frame_ff;
      end
      if (cmd.emit_step) begin
         kind_ff   <= KIND_STEP;
         last_ff   <= 1'b0;
         ostep_ff  <= StepW'(fstep_ff);
         ofixed_ff <= OutTimeW'(fixed_next);
      end
      if (cmd.emit_frame) begin
         kind_ff   <= KIND_FRAME;
         last_ff   <= 1'b1;
         ostep_ff  <= delta_ff;
         ofixed_ff <= OutTimeW'(fixed_ff);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {oframe_ff, ofixed_ff, ounscaled_ff, ogame_ff, ostep_ff};

endmodule

// ===== design/fixed_timestep_frame_timer_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_timestep_frame_timer_unit : fixed-timestep frame timer
// game, unscaled and fixed time accumulation with serial step results
// ----------------------------------------------------------------------------
// A tick transaction (req_tuser low) adds its elapsed microseconds to the
// unscaled time and, clamped and scaled by the Q8.8 time scale, to the game
// time; the block then emits one fixed-step result per owed step (at most
// MAX_FIXED_STEPS, the rest carried to later ticks) and closes with a frame
// result marked by rsp_tlast. A restart transaction (req_tuser high) clears
// the times, keeps the frame count and gives no result; the tick after it
// counts as zero elapsed. A tick passes through capture and clamp, the
// scaling multiply and accumulation, then the result loop, which sends each
// result through the single result register and is stretched by any
// back-pressure on rsp. The next transaction is taken once the frame
// result sits in the result register, while that result still waits to
// be collected.
// Register writes are taken in any cycle and belong only in idle periods.
// ----------------------------------------------------------------------------
module fixed_timestep_frame_timer_unit #(
   parameter int MAX_FIXED_STEPS = 63,   // 1 to 63
   parameter int TIME_WIDTH      = 48    // 32 to 64, accumulator width
) (
   input  logic                          clock,
   input  logic                          reset,
   // input stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fst_pkg::ElapsedW-1:0]  req_tdata,   // [31:0] elapsed_us
   input  logic                          req_tuser,   // [0] op
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fst_pkg::RspDataW-1:0]  rsp_tdata,   // [31:0] step_us,
                                                      // [79:32] game_time_us,
                                                      // [127:80] unscaled_time_us,
                                                      // [175:128] fixed_time_us,
                                                      // [223:176] frame_number
   output logic                          rsp_tuser,   // [0] kind
   output logic                          rsp_tlast,
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fst_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [fst_pkg::CsrDataW-1:0]  csr_data
);
   import fst_pkg::*;

   fst_cmd_type    cmd;
   fst_status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   // sequencing: idle, scale, accumulate, result loop
   fst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic, timer state and result register
   fst_dp #(
      .MAX_FIXED_STEPS (MAX_FIXED_STEPS),
      .TIME_WIDTH      (TIME_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .elapsed    (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
